// ===== sv/rmap_hb_pkg.sv =====
// Shared types and constants for the RMAP command header builder.
package rmap_hb_pkg;

    // Longest reply path the header may carry, in bytes
    localparam int unsigned MAX_REPLY_PATH = 12;

    // Fixed header bytes and instruction bits
    localparam logic [7:0] PROTOCOL_ID  = 8'h01;
    localparam logic [7:0] INSTR_BASE   = 8'h40;
    localparam logic [7:0] INSTR_WRITE  = 8'h20;
    localparam logic [7:0] INSTR_VERIFY = 8'h10;
    localparam logic [7:0] INSTR_ACK    = 8'h08;
    localparam logic [7:0] INSTR_INC    = 8'h04;

    // Largest data length accepted for read-modify-write
    localparam logic [3:0] RMW_MAX_LEN  = 4'd8;

    // Request type codes
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_RMW     = 2'd2,
        REQ_INVALID = 2'd3
    } t_req_type;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET    = 3'd0,
        CFG_KEY       = 3'd1,
        CFG_INITIATOR = 3'd2,
        CFG_PATH_LEN  = 3'd3,
        CFG_PATH_LOW  = 3'd4,
        CFG_PATH_HIGH = 3'd5
    } t_cfg_idx;

    // Input request payload
    typedef struct packed {
        logic [1:0]  req_type;
        logic        verify_data;
        logic        require_ack;
        logic        increment_addr;
        logic [15:0] transaction_id;
        logic [7:0]  extended_addr;
        logic [31:0] memory_addr;
        logic [23:0] data_len;
    } t_hb_req;

    // Output header byte payload
    typedef struct packed {
        logic [7:0] header_byte;
        logic       error;
        logic       last;
    } t_hb_hdr;

    // Configuration write payload
    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] value;
    } t_hb_cfg;

    // Configuration registers seen by the byte sequencer
    typedef struct packed {
        logic [7:0]  target_address;
        logic [7:0]  dest_key;
        logic [7:0]  initiator_address;
        logic [95:0] reply_path;
    } t_hb_regs;

    // Classified command passed from front to back through the queue
    typedef struct packed {
        logic        error;
        logic [3:0]  plen;
        logic [1:0]  pad;
        logic [7:0]  instr;
        logic [15:0] transaction_id;
        logic [7:0]  extended_addr;
        logic [31:0] memory_addr;
        logic [23:0] data_len;
    } t_hb_cmd;

    // Header field currently being sent
    typedef enum logic [3:0] {
        S_TGT,
        S_PID,
        S_INSTR,
        S_KEY,
        S_PAD,
        S_PATH,
        S_INIT,
        S_TID,
        S_EXT,
        S_ADDR,
        S_LEN
    } t_hb_state;

endpackage

// ===== sv/rmap_hb_if.sv =====
// Valid/ready channel interface carrying one payload per transfer.
interface rmap_hb_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rmap_command_header_builder.sv =====
// Top level of the RMAP command header builder: configuration registers and datapath.
// Each accepted command request yields its RMAP command header (without CRC) on o_hdr,
// one byte per transfer, numeric fields most significant byte first, the reply path lowest
// byte first, with last set on the final length byte: 15 bytes plus the reply path padded
// to a multiple of four (15 to 27 bytes). A rejected request yields a single result with
// error and last set. The byte sequencer emits one byte per cycle while the sink is ready
// and sets the rate; the front end and a short command queue accept and check the next
// requests while the current header is still going out. Configuration registers are
// written through i_cfg (always ready) and must only change while no request is pending.
module rmap_command_header_builder
    import rmap_hb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmap_hb_if.sink   i_cfg,
    rmap_hb_if.sink   i_req,
    rmap_hb_if.source o_hdr
);

    localparam int CmdW = $bits(t_hb_cmd);

    logic [7:0]  r_target;
    logic [7:0]  r_key;
    logic [7:0]  r_initiator;
    logic [3:0]  r_plen;
    logic [63:0] r_path_low;
    logic [31:0] r_path_high;

    t_hb_regs        regs;
    logic            push;
    t_hb_cmd         push_cmd;
    logic            q_full;
    logic            q_valid;
    logic [CmdW-1:0] q_data;
    logic            q_pop;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 8'd254;
            r_key       <= 8'd0;
            r_initiator <= 8'd254;
            r_plen      <= 4'd0;
            r_path_low  <= 64'd0;
            r_path_high <= 32'd0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.data.index))
                CFG_TARGET:    r_target    <= i_cfg.data.value[7:0];
                CFG_KEY:       r_key       <= i_cfg.data.value[7:0];
                CFG_INITIATOR: r_initiator <= i_cfg.data.value[7:0];
                CFG_PATH_LEN:  r_plen      <= i_cfg.data.value[3:0];
                CFG_PATH_LOW:  r_path_low  <= i_cfg.data.value;
                CFG_PATH_HIGH: r_path_high <= i_cfg.data.value[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        regs.target_address    = r_target;
        regs.dest_key          = r_key;
        regs.initiator_address = r_initiator;
        regs.reply_path        = {r_path_high, r_path_low};
    end

    // Request checking
    rmap_hb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_plen  (r_plen),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (q_full)
    );

    // Command queue
    rmap_hb_queue #(
        .WIDTH (CmdW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    // Header byte sequencer
    rmap_hb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_regs    (regs),
        .i_q_valid (q_valid),
        .i_q_cmd   (t_hb_cmd'(q_data)),
        .o_pop     (q_pop),
        .o_hdr     (o_hdr)
    );

endmodule

// ===== sv/rmap_hb_front.sv =====
// Front end: accepts a command request, validates it and builds the instruction byte.
module rmap_hb_front
    import rmap_hb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    rmap_hb_if.sink          i_req,
    input  logic [3:0]       i_plen,
    output logic             o_push,
    output t_hb_cmd          o_cmd,
    input  logic             i_full
);

    logic    r_valid;
    t_hb_cmd r_cmd;
    t_hb_cmd n_cmd;
    logic    bad;
    logic    rmw_len_ok;
    logic [4:0] units_sum;
    t_req_type rtype;

    // Hold one classified command until the queue takes it
    assign i_req.ready = !r_valid || !i_full;
    assign o_push      = r_valid;
    assign o_cmd       = r_cmd;

    // Validation and instruction byte
    always_comb begin
        rtype      = t_req_type'(i_req.data.req_type);
        rmw_len_ok = (i_req.data.data_len[23:4] == '0) && !i_req.data.data_len[0]
                     && (i_req.data.data_len[3:0] <= RMW_MAX_LEN);
        bad = 1'b0;
        if (rtype == REQ_INVALID) begin
            bad = 1'b1;
        end
        if (32'(i_plen) > MAX_REPLY_PATH) begin
            bad = 1'b1;
        end
        if (rtype == REQ_READ && (!i_req.data.require_ack || i_req.data.verify_data)) begin
            bad = 1'b1;
        end
        if (rtype == REQ_RMW && (!rmw_len_ok || !i_req.data.require_ack
                                 || !i_req.data.increment_addr)) begin
            bad = 1'b1;
        end

        // reply path length in 4-byte words, rounded up
        units_sum = {1'b0, i_plen} + 5'd3;

        n_cmd.error = bad;
        n_cmd.plen  = i_plen;
        n_cmd.pad   = 2'(~i_plen[1:0] + 2'd1);
        n_cmd.instr = INSTR_BASE | {6'd0, units_sum[3:2]};
        if (rtype == REQ_WRITE) begin
            n_cmd.instr = n_cmd.instr | INSTR_WRITE;
        end
        if (rtype == REQ_RMW || i_req.data.verify_data) begin
            n_cmd.instr = n_cmd.instr | INSTR_VERIFY;
        end
        if (i_req.data.require_ack) begin
            n_cmd.instr = n_cmd.instr | INSTR_ACK;
        end
        if (i_req.data.increment_addr) begin
            n_cmd.instr = n_cmd.instr | INSTR_INC;
        end
        n_cmd.transaction_id = i_req.data.transaction_id;
        n_cmd.extended_addr  = i_req.data.extended_addr;
        n_cmd.memory_addr    = i_req.data.memory_addr;
        n_cmd.data_len       = i_req.data.data_len;
    end

    // Command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_valid <= 1'b1;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== sv/rmap_hb_queue.sv =====
// Short first-in first-out queue of commands between front end and sequencer.
module rmap_hb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

// ===== sv/rmap_hb_back.sv =====
// Back end: sequences the header bytes of each command into the output register.
module rmap_hb_back
    import rmap_hb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_hb_regs         i_regs,
    input  logic             i_q_valid,
    input  t_hb_cmd          i_q_cmd,
    output logic             o_pop,
    rmap_hb_if.source        o_hdr
);

    t_hb_state r_state, n_state;
    logic [3:0] r_sub, n_sub;
    logic       r_busy, n_busy;
    t_hb_cmd    r_cmd, n_cmd;
    logic       r_out_valid, n_out_valid;
    t_hb_hdr    r_out, n_out;

    logic       adv;
    logic       done;
    logic       finish;
    logic       cur_last;
    logic [7:0] cur_byte;
    logic [3:0] field_len;
    t_hb_state  after_key;

    assign o_hdr.valid = r_out_valid;
    assign o_hdr.data  = r_out;

    // State, counter and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_TGT;
            r_sub       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sub       <= n_sub;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    // Byte select, next state and queue pop
    always_comb begin
        after_key = (r_cmd.pad != '0) ? S_PAD : ((r_cmd.plen != '0) ? S_PATH : S_INIT);
        cur_byte  = '0;
        field_len = 4'd1;
        n_state   = r_state;
        unique case (r_state)
            S_TGT: begin
                cur_byte = i_regs.target_address;
                n_state  = S_PID;
            end
            S_PID: begin
                cur_byte = PROTOCOL_ID;
                n_state  = S_INSTR;
            end
            S_INSTR: begin
                cur_byte = r_cmd.instr;
                n_state  = S_KEY;
            end
            S_KEY: begin
                cur_byte = i_regs.dest_key;
                n_state  = after_key;
            end
            S_PAD: begin
                field_len = {2'd0, r_cmd.pad};
                n_state   = (r_cmd.plen != '0) ? S_PATH : S_INIT;
            end
            S_PATH: begin
                cur_byte  = i_regs.reply_path[{r_sub, 3'b000} +: 8];
                field_len = r_cmd.plen;
                n_state   = S_INIT;
            end
            S_INIT: begin
                cur_byte = i_regs.initiator_address;
                n_state  = S_TID;
            end
            S_TID: begin
                cur_byte  = r_sub[0] ? r_cmd.transaction_id[7:0]
                                     : r_cmd.transaction_id[15:8];
                field_len = 4'd2;
                n_state   = S_EXT;
            end
            S_EXT: begin
                cur_byte = r_cmd.extended_addr;
                n_state  = S_ADDR;
            end
            S_ADDR: begin
                cur_byte  = r_cmd.memory_addr[{~r_sub[1:0], 3'b000} +: 8];
                field_len = 4'd4;
                n_state   = S_LEN;
            end
            S_LEN: begin
                case (r_sub[1:0])
                    2'd0:    cur_byte = r_cmd.data_len[23:16];
                    2'd1:    cur_byte = r_cmd.data_len[15:8];
                    default: cur_byte = r_cmd.data_len[7:0];
                endcase
                field_len = 4'd3;
                n_state   = S_LEN;
            end
            default: begin
                n_state = S_TGT;
            end
        endcase

        done     = (r_sub == field_len - 4'd1);
        cur_last = r_cmd.error || (r_state == S_LEN && done);
        if (r_cmd.error) begin
            cur_byte = '0;
        end
        adv    = !r_out_valid || o_hdr.ready;
        finish = r_busy && cur_last;

        if (!(adv && r_busy && done && !cur_last)) begin
            n_state = r_state;
        end
        n_sub       = r_sub;
        n_busy      = r_busy;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_hdr.ready;
        o_pop       = 1'b0;

        // one header byte per free output slot
        if (adv && r_busy) begin
            n_out_valid       = 1'b1;
            n_out.header_byte = cur_byte;
            n_out.error       = r_cmd.error;
            n_out.last        = cur_last;
            if (finish) begin
                n_busy = 1'b0;
            end else if (done) begin
                n_sub = '0;
            end else begin
                n_sub = r_sub + 4'd1;
            end
        end

        // take the next command when idle or as the current one ends
        if (adv && (!r_busy || finish) && i_q_valid) begin
            o_pop   = 1'b1;
            n_cmd   = i_q_cmd;
            n_busy  = 1'b1;
            n_state = S_TGT;
            n_sub   = '0;
        end
    end

`ifndef ASSERT_OFF
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |-> (r_out.last && r_out.header_byte == '0))
        else $error("rejected request result malformed");

    a_path_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_state == S_PATH) |-> (r_sub < r_cmd.plen))
        else $error("reply path index out of range");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && finish && !i_q_valid) |=> !r_busy)
        else $error("sequencer still busy after last byte");

    a_error_no_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.error) |-> (r_state == S_TGT))
        else $error("rejected command advanced past first result");
`endif

endmodule

// ===== tb/rmap_command_header_builder_test.sv =====
// Testbench for the RMAP command header builder: directed and random requests checked byte by byte.
`timescale 1ns / 100ps

module rmap_command_header_builder_test;
    import rmap_hb_pkg::*;

    localparam int     CLK_HALF_NS           = 1;
    localparam int     RESET_CYCLES          = 10;
    localparam int     MAX_IDLE              = 8;
    localparam int     SETTLE_CYCLES         = 60;
    localparam int     DRAIN_LIMIT           = 200000;
    localparam int     SINK_HOLD_CYCLES      = 400;
    localparam int     RANDOM_PHASES         = 7;
    localparam int     PHASE_REQUESTS        = 55;
    localparam int     REJECT_PHASE_REQUESTS = 30;
    localparam int     REJECT_PHASE          = 6;
    localparam int     HOLD_PHASE            = 1;
    localparam int     HOLD_AFTER            = 10;
    localparam int     REPORT_LIMIT          = 10;
    localparam longint TIMEOUT_NS            = 2_000_000;

    // Register indexes past the end of the map; writes there must change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Expected header bytes for every accepted request, checked in order
    class rmap_header_predictor;
        logic [7:0]  target_address;
        logic [7:0]  dest_key;
        logic [7:0]  initiator_address;
        logic [3:0]  path_len;
        logic [63:0] path_low;
        logic [31:0] path_high;
        t_hb_hdr     expected_bytes[$];
        int          mismatches;

        function new();
            target_address    = 8'hfe;
            dest_key          = 8'h00;
            initiator_address = 8'hfe;
            path_len          = '0;
            path_low          = '0;
            path_high         = '0;
            mismatches        = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [63:0] value);
            case (index)
                CFG_TARGET:    target_address    = value[7:0];
                CFG_KEY:       dest_key          = value[7:0];
                CFG_INITIATOR: initiator_address = value[7:0];
                CFG_PATH_LEN:  path_len          = value[3:0];
                CFG_PATH_LOW:  path_low          = value;
                CFG_PATH_HIGH: path_high         = value[31:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] value, logic last);
            t_hb_hdr b;
            b.header_byte = value;
            b.error       = 1'b0;
            b.last        = last;
            expected_bytes.push_back(b);
        endfunction

        // One accepted request: either a single rejection or the full header
        function void add_request(t_hb_req r);
            t_req_type   kind;
            logic [95:0] path;
            logic [7:0]  instr;
            t_hb_hdr     reject;
            int          units;
            int          pad;
            bit          rejected;
            kind = t_req_type'(r.req_type);
            rejected = (kind == REQ_INVALID) || (path_len > MAX_REPLY_PATH);
            if (kind == REQ_READ && (!r.require_ack || r.verify_data))
                rejected = 1'b1;
            // RMW length must be even and no more than eight
            if (kind == REQ_RMW && (r.data_len > RMW_MAX_LEN || r.data_len[0] ||
                                    !r.require_ack || !r.increment_addr))
                rejected = 1'b1;
            if (rejected) begin
                reject.header_byte = 8'h00;
                reject.error       = 1'b1;
                reject.last        = 1'b1;
                expected_bytes.push_back(reject);
            end else begin
                units = (int'(path_len) + 3) / 4;
                pad   = (4 - int'(path_len) % 4) % 4;
                instr = INSTR_BASE;
                if (kind == REQ_WRITE)
                    instr = instr | INSTR_WRITE;
                if (kind == REQ_RMW || r.verify_data)
                    instr = instr | INSTR_VERIFY;
                if (r.require_ack)
                    instr = instr | INSTR_ACK;
                if (r.increment_addr)
                    instr = instr | INSTR_INC;
                instr[1:0] = units[1:0];
                path = {path_high, path_low};

                push_byte(target_address, 1'b0);
                push_byte(PROTOCOL_ID, 1'b0);
                push_byte(instr, 1'b0);
                push_byte(dest_key, 1'b0);
                for (int i = 0; i < pad; i++)
                    push_byte(8'h00, 1'b0);
                for (int i = 0; i < int'(path_len); i++)
                    push_byte(path[8*i +: 8], 1'b0);
                push_byte(initiator_address, 1'b0);
                push_byte(r.transaction_id[15:8], 1'b0);
                push_byte(r.transaction_id[7:0], 1'b0);
                push_byte(r.extended_addr, 1'b0);
                push_byte(r.memory_addr[31:24], 1'b0);
                push_byte(r.memory_addr[23:16], 1'b0);
                push_byte(r.memory_addr[15:8], 1'b0);
                push_byte(r.memory_addr[7:0], 1'b0);
                push_byte(r.data_len[23:16], 1'b0);
                push_byte(r.data_len[15:8], 1'b0);
                push_byte(r.data_len[7:0], 1'b1);
            end
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_byte(t_hb_hdr got);
            t_hb_hdr want;
            if (expected_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected header transfer: byte %02h error %b last %b",
                                        got.header_byte, got.error, got.last));
            end else begin
                want = expected_bytes.pop_front();
                if (got.header_byte !== want.header_byte || got.error !== want.error ||
                    got.last !== want.last)
                    note_mismatch($sformatf(
                        "header byte: expected %02h error %b last %b, got %02h error %b last %b",
                        want.header_byte, want.error, want.last,
                        got.header_byte, got.error, got.last));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rmap_hb_if #(.t_payload(t_hb_cfg)) cfg_if ();
    rmap_hb_if #(.t_payload(t_hb_req)) req_if ();
    rmap_hb_if #(.t_payload(t_hb_hdr)) hdr_if ();

    rmap_header_predictor pred;
    bit                   src_idle_on;
    bit                   sink_idle_on;
    int                   hold_sink_cycles;

    rmap_command_header_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_hdr   (hdr_if)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF_NS i_clk = ~i_clk;

    // Watch every channel; register writes and requests first, then results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                pred.write_register(cfg_if.data.index, cfg_if.data.value);
            if (req_if.valid && req_if.ready)
                pred.add_request(req_if.data);
            if (hdr_if.valid && hdr_if.ready)
                pred.check_byte(hdr_if.data);
        end
    end

    function automatic int idle_cycles(bit on);
        return on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic t_hb_req make_request(t_req_type kind, bit verify, bit ack, bit inc,
                                             logic [15:0] tid, logic [7:0] ext,
                                             logic [31:0] addr, logic [23:0] len);
        t_hb_req r;
        r.req_type       = kind;
        r.verify_data    = verify;
        r.require_ack    = ack;
        r.increment_addr = inc;
        r.transaction_id = tid;
        r.extended_addr  = ext;
        r.memory_addr    = addr;
        r.data_len       = len;
        return r;
    endfunction

    // Mostly well-formed commands with random content, some with short lengths, the rest raw noise
    function automatic t_hb_req random_request();
        t_hb_req     r;
        t_req_type   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = $urandom;
        b = $urandom;
        c = $urandom;
        r.req_type       = a[1:0];
        r.verify_data    = a[2];
        r.require_ack    = a[3];
        r.increment_addr = a[4];
        r.extended_addr  = a[15:8];
        r.transaction_id = a[31:16];
        r.memory_addr    = b;
        r.data_len       = c[23:0];
        if (c[31:28] < 4'd11) begin
            kind = t_req_type'($urandom_range(REQ_WRITE, REQ_RMW));
            r.req_type = kind;
            case (kind)
                REQ_READ: begin
                    r.require_ack = 1'b1;
                    r.verify_data = 1'b0;
                end
                REQ_RMW: begin
                    r.require_ack    = 1'b1;
                    r.increment_addr = 1'b1;
                    r.data_len       = 24'($urandom_range(0, RMW_MAX_LEN / 2) * 2);
                end
                default: ;
            endcase
        end else if (c[31:28] < 4'd13) begin
            // short lengths around the RMW limit
            r.data_len = 24'($urandom_range(0, 2 * RMW_MAX_LEN));
        end
        return r;
    endfunction

    task automatic write_register(logic [2:0] index, logic [63:0] value);
        cfg_if.valid      <= 1'b1;
        cfg_if.data.index <= index;
        cfg_if.data.value <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic apply_settings(logic [63:0] tgt, logic [63:0] key, logic [63:0] init,
                                  logic [63:0] plen, logic [63:0] low, logic [63:0] high,
                                  bit with_spare);
        write_register(CFG_TARGET, tgt);
        write_register(CFG_KEY, key);
        write_register(CFG_INITIATOR, init);
        write_register(CFG_PATH_LEN, plen);
        write_register(CFG_PATH_LOW, low);
        write_register(CFG_PATH_HIGH, high);
        if (with_spare) begin
            write_register(CFG_SPARE_LO, {$urandom, $urandom});
            write_register(CFG_SPARE_HI, {$urandom, $urandom});
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_request(t_hb_req r);
        int gap;
        gap = idle_cycles(src_idle_on);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Stop offering, wait for every expected byte, then let the block settle
    task automatic finish_phase();
        int waited;
        req_if.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pred.expected_bytes.size() != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result sink: random stalls per transfer, plus one long hold on request
    initial begin
        int stall;
        hdr_if.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = hold_sink_cycles + idle_cycles(sink_idle_on);
            hold_sink_cycles = 0;
            if (stall > 0) begin
                hdr_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            hdr_if.ready <= 1'b1;
            do @(posedge i_clk); while (!hdr_if.valid);
        end
    end

    // Stimulus
    initial begin
        int count;
        pred             = new();
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        req_if.valid     = 1'b0;
        req_if.data      = '0;
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b0;
        hold_sink_cycles = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: field extremes, every command kind, every rejection of the request fields
        send_request(make_request(REQ_WRITE, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00,
                                  32'h0000_0000, 24'h00_0000));
        send_request(make_request(REQ_WRITE, 1'b1, 1'b1, 1'b1, 16'hffff, 8'hff,
                                  32'hffff_ffff, 24'hff_ffff));
        send_request(make_request(REQ_READ, 1'b0, 1'b1, 1'b1, 16'h1234, 8'h5a,
                                  32'h89ab_cdef, 24'h12_3456));
        send_request(make_request(REQ_READ, 1'b0, 1'b0, 1'b1, 16'h0001, 8'h01,
                                  32'h0000_0001, 24'h00_0010));
        send_request(make_request(REQ_READ, 1'b1, 1'b1, 1'b0, 16'h0002, 8'h02,
                                  32'h0000_0002, 24'h00_0020));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a0, 8'h10,
                                  32'h1000_0000, 24'h00_0000));
        send_request(make_request(REQ_RMW, 1'b1, 1'b1, 1'b1, 16'h00a1, 8'h11,
                                  32'h2000_0000, 24'h00_0002));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a2, 8'h12,
                                  32'h3000_0000, 24'h00_0004));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a3, 8'h13,
                                  32'h4000_0000, 24'h00_0006));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a4, 8'h14,
                                  32'h5000_0000, 24'h00_0008));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a5, 8'h15,
                                  32'h6000_0000, 24'h00_0003));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a6, 8'h16,
                                  32'h7000_0000, 24'h00_0009));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b1, 16'h00a7, 8'h17,
                                  32'h8000_0000, 24'hff_ffff));
        send_request(make_request(REQ_RMW, 1'b0, 1'b0, 1'b1, 16'h00a8, 8'h18,
                                  32'h9000_0000, 24'h00_0008));
        send_request(make_request(REQ_RMW, 1'b0, 1'b1, 1'b0, 16'h00a9, 8'h19,
                                  32'ha000_0000, 24'h00_0008));
        send_request(make_request(REQ_INVALID, 1'b1, 1'b1, 1'b1, 16'hbeef, 8'hee,
                                  32'hdead_beef, 24'h00_0004));
        finish_phase();

        // Longest legal reply path with all-ones bytes
        apply_settings(8'h00, 8'hff, 8'hff, MAX_REPLY_PATH, '1, '1, 1'b0);
        send_request(make_request(REQ_WRITE, 1'b0, 1'b1, 1'b0, 16'h4321, 8'h80,
                                  32'h0102_0304, 24'h00_0100));
        send_request(make_request(REQ_READ, 1'b0, 1'b1, 1'b0, 16'h8765, 8'h7f,
                                  32'hfffe_fdfc, 24'h80_0000));
        finish_phase();

        // Empty reply path, opposite register extremes
        apply_settings(8'hff, 8'h00, 8'h00, 4'd0, '0, '0, 1'b0);
        send_request(make_request(REQ_WRITE, 1'b1, 1'b0, 1'b1, 16'h5555, 8'haa,
                                  32'h5555_aaaa, 24'h55_aaaa));
        finish_phase();

        // Reply paths over the limit reject even well-formed writes
        apply_settings(8'h11, 8'h22, 8'h33, MAX_REPLY_PATH + 1, '1, '1, 1'b0);
        send_request(make_request(REQ_WRITE, 1'b0, 1'b1, 1'b1, 16'h0f0f, 8'h0f,
                                  32'h0f0f_0f0f, 24'h0f_0f0f));
        finish_phase();
        apply_settings(8'h11, 8'h22, 8'h33, 4'hf, '1, '1, 1'b0);
        send_request(make_request(REQ_WRITE, 1'b0, 1'b1, 1'b1, 16'hf0f0, 8'hf0,
                                  32'hf0f0_f0f0, 24'hf0_f0f0));
        finish_phase();

        // Random phases; they cycle through every reply path padding, and one uses a path over the limit
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == REJECT_PHASE)
                apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom},
                               $urandom_range(MAX_REPLY_PATH + 1, 15),
                               {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
            else
                apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom},
                               4 * $urandom_range(0, 2) + p % 4,
                               {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
            src_idle_on  = (p % 3) != 0;
            sink_idle_on = (p % 2) != 0;
            count = (p == REJECT_PHASE) ? REJECT_PHASE_REQUESTS : PHASE_REQUESTS;
            for (int n = 0; n < count; n++) begin
                // long sink hold while requests keep coming: queue fills, input stalls
                if (p == HOLD_PHASE && n == HOLD_AFTER)
                    hold_sink_cycles = SINK_HOLD_CYCLES;
                send_request(random_request());
            end
            finish_phase();
        end

        if (pred.expected_bytes.size() != 0)
            pred.note_mismatch($sformatf("%0d expected header bytes never arrived",
                                         pred.expected_bytes.size()));
        if (pred.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rmap_hb_pkg.sv
sv/rmap_hb_if.sv
sv/rmap_hb_front.sv
sv/rmap_hb_queue.sv
sv/rmap_hb_back.sv
sv/rmap_command_header_builder.sv
tb/rmap_command_header_builder_test.sv
